>>> hdl/assert_macros.svh
// Assertion macros shared by the block position mapper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/cbpm_pkg.sv
// Types and codes shared by the block position mapper modules.
package cbpm_pkg;

  localparam int unsigned PosW = 31;
  localparam int unsigned LenW = 28;
  localparam logic [PosW-1:0] PosMax = '1;

  // Input item kinds.
  localparam logic [1:0] KindStart     = 2'd0;
  localparam logic [1:0] KindCigar     = 2'd1;
  localparam logic [1:0] KindRefQuery  = 2'd2;
  localparam logic [1:0] KindReadQuery = 2'd3;

  // CIGAR operation codes that change state.
  localparam logic [3:0] OpMatch = 4'd0;
  localparam logic [3:0] OpIns   = 4'd1;
  localparam logic [3:0] OpDel   = 4'd2;
  localparam logic [3:0] OpSkip  = 4'd3;
  localparam logic [3:0] OpSoft  = 4'd4;
  localparam logic [3:0] OpEqual = 4'd7;
  localparam logic [3:0] OpDiff  = 4'd8;

  // Result kinds.
  localparam logic [1:0] ResEnd     = 2'd0;
  localparam logic [1:0] ResReadPos = 2'd1;
  localparam logic [1:0] ResRefPos  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PosW-1:0]   alignment_start;
    logic              unmapped;
    logic [3:0]        op_code;
    logic [LenW-1:0]   op_length;
    logic              last_op;
    logic signed [31:0] query_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      result_kind;
    logic [PosW-1:0] position_value;
    logic            table_overflow;
  } out_item_t;

  // One aligned block of the table.
  typedef struct packed {
    logic [PosW-1:0] read_start;
    logic [PosW-1:0] ref_start;
    logic [LenW-1:0] length;
  } block_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic walk;
    logic load_query;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic item_result;
    logic walk_done;
  } status_t;

endpackage

>>> hdl/cbpm_datapath.sv
// Datapath of the block position mapper: cursors, block table, query walk and result register.
module cbpm_datapath import cbpm_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_data_i,
  output status_t   status_o,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // Adds a length to a position, saturating at the largest position.
  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [PosW:0] sum;
    sum = {1'b0, a} + {{(PosW + 1 - LenW){1'b0}}, b};
    return sum[PosW] ? PosMax : sum[PosW-1:0];
  endfunction

  logic [CntW-1:0] count_q, count_d;
  logic [PosW-1:0] read_cur_q, read_cur_d;
  logic [PosW-1:0] ref_cur_q, ref_cur_d;
  logic [PosW-1:0] span_q, span_d;
  logic [PosW-1:0] start_q, start_d;
  logic            unmapped_q, unmapped_d;
  logic            overflow_q, overflow_d;

  logic [PosW-1:0] qry_pos_q, qry_pos_d;
  logic            qry_bad_q, qry_bad_d;
  logic            qry_rev_q, qry_rev_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rdv_q, rdv_d;
  logic [PosW-1:0] res_q, res_d;
  out_item_t       out_q, out_d;

  block_t          mem_q [MAX_BLOCKS];
  block_t          rd_q;
  block_t          wr_block;
  logic            wr_en;
  logic            rd_en;

  logic            is_ins_soft, is_gap, is_aligned, table_full;
  logic [PosW-1:0] read_adv, ref_adv, span_adv;
  logic [PosW:0]   start_inc;
  logic [PosW:0]   end_sum, end_m1;
  logic [PosW-1:0] end_val;

  logic [PosW-1:0] blk_s, blk_o;
  logic [PosW:0]   blk_end_x;
  logic [PosW-1:0] blk_diff;
  logic [PosW:0]   mapped;
  logic [PosW-1:0] map_val;
  logic            hit, pre_start, found;

  // Operation decode and saturating cursor advances.
  assign is_ins_soft = (in_data_i.op_code == OpIns) || (in_data_i.op_code == OpSoft);
  assign is_gap      = (in_data_i.op_code == OpDel) || (in_data_i.op_code == OpSkip);
  assign is_aligned  = (in_data_i.op_code == OpMatch) || (in_data_i.op_code == OpEqual) ||
                       (in_data_i.op_code == OpDiff);
  assign table_full  = (count_q == CntW'(MAX_BLOCKS));
  assign read_adv    = sat_add(read_cur_q, in_data_i.op_length);
  assign ref_adv     = sat_add(ref_cur_q, in_data_i.op_length);
  assign span_adv    = sat_add(span_q, in_data_i.op_length);
  assign start_inc   = {1'b0, in_data_i.alignment_start} + {{PosW{1'b0}}, 1'b1};

  assign wr_block.read_start = read_cur_q;
  assign wr_block.ref_start  = ref_cur_q;
  assign wr_block.length     = in_data_i.op_length;

  // Alignment end from the span after this operation; the start is always at least one.
  assign end_sum = {1'b0, start_q} + {1'b0, span_d};
  assign end_m1  = end_sum - {{PosW{1'b0}}, 1'b1};
  assign end_val = unmapped_q ? '0 : (end_m1[PosW] ? PosMax : end_m1[PosW-1:0]);

  // Evaluation of the block read in the previous cycle.
  assign blk_s     = qry_rev_q ? rd_q.read_start : rd_q.ref_start;
  assign blk_o     = qry_rev_q ? rd_q.ref_start : rd_q.read_start;
  assign blk_end_x = {1'b0, blk_s} + {{(PosW + 1 - LenW){1'b0}}, rd_q.length};
  assign hit       = blk_end_x > {1'b0, qry_pos_q};
  assign pre_start = qry_pos_q < blk_s;
  assign blk_diff  = qry_pos_q - blk_s;
  assign mapped    = {1'b0, blk_o} + {1'b0, blk_diff};
  assign map_val   = mapped[PosW] ? PosMax : mapped[PosW-1:0];
  assign found     = rdv_q && hit;

  assign rd_en = cmd_i.walk && (idx_q < count_q);

  // Next-state logic for cursors, table fill, query walk and the result register.
  always_comb begin
    count_d    = count_q;
    read_cur_d = read_cur_q;
    ref_cur_d  = ref_cur_q;
    span_d     = span_q;
    start_d    = start_q;
    unmapped_d = unmapped_q;
    overflow_d = overflow_q;
    qry_pos_d  = qry_pos_q;
    qry_bad_d  = qry_bad_q;
    qry_rev_d  = qry_rev_q;
    idx_d      = idx_q;
    rdv_d      = rdv_q;
    res_d      = res_q;
    out_d      = out_q;
    wr_en      = 1'b0;

    if (cmd_i.accept) begin
      case (in_data_i.kind)
        KindStart: begin
          count_d    = '0;
          overflow_d = 1'b0;
          read_cur_d = {{(PosW - 1){1'b0}}, 1'b1};
          start_d    = start_inc[PosW] ? PosMax : start_inc[PosW-1:0];
          ref_cur_d  = start_d;
          span_d     = '0;
          unmapped_d = in_data_i.unmapped;
        end
        KindCigar: begin
          if (is_ins_soft) begin
            read_cur_d = read_adv;
          end else if (is_gap) begin
            ref_cur_d = ref_adv;
            span_d    = span_adv;
          end else if (is_aligned) begin
            if (table_full) begin
              overflow_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + {{(CntW - 1){1'b0}}, 1'b1};
            end
            read_cur_d = read_adv;
            ref_cur_d  = ref_adv;
            span_d     = span_adv;
          end
          if (in_data_i.last_op) begin
            out_d.result_kind    = ResEnd;
            out_d.position_value = end_val;
            out_d.table_overflow = overflow_d;
          end
        end
        default: begin
          qry_pos_d = in_data_i.query_position[PosW-1:0];
          qry_bad_d = in_data_i.query_position[31] || (in_data_i.query_position == '0);
          qry_rev_d = (in_data_i.kind == KindReadQuery);
          idx_d     = '0;
          rdv_d     = 1'b0;
        end
      endcase
    end

    if (cmd_i.walk) begin
      rdv_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + {{(CntW - 1){1'b0}}, 1'b1};
      end
      res_d = (qry_bad_q || !found || pre_start) ? '0 : map_val;
    end

    if (cmd_i.load_query) begin
      out_d.result_kind    = qry_rev_q ? ResRefPos : ResReadPos;
      out_d.position_value = res_q;
      out_d.table_overflow = overflow_q;
    end
  end

  // Control and cursor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      read_cur_q <= {{(PosW - 1){1'b0}}, 1'b1};
      ref_cur_q  <= {{(PosW - 1){1'b0}}, 1'b1};
      span_q     <= '0;
      start_q    <= {{(PosW - 1){1'b0}}, 1'b1};
      unmapped_q <= 1'b0;
      overflow_q <= 1'b0;
      idx_q      <= '0;
      rdv_q      <= 1'b0;
    end else begin
      count_q    <= count_d;
      read_cur_q <= read_cur_d;
      ref_cur_q  <= ref_cur_d;
      span_q     <= span_d;
      start_q    <= start_d;
      unmapped_q <= unmapped_d;
      overflow_q <= overflow_d;
      idx_q      <= idx_d;
      rdv_q      <= rdv_d;
    end
  end

  // Query and result payload registers.
  always_ff @(posedge clk_i) begin
    qry_pos_q <= qry_pos_d;
    qry_bad_q <= qry_bad_d;
    qry_rev_q <= qry_rev_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Block table: one write at the fill count, one registered read at the walk index.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IdxW-1:0]] <= wr_block;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  assign status_o.is_query    = in_data_i.kind[1];
  assign status_o.item_result = (in_data_i.kind == KindCigar) && in_data_i.last_op;
  assign status_o.walk_done   = qry_bad_q || found || (idx_q >= count_q);
  assign out_data_o           = out_q;

`include "assert_macros.svh"

  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MAX_BLOCKS), "block count exceeds table size")
  `ASSERT_PROP(a_overflow_full, clk_i, rst_ni, $rose(overflow_q) |-> $past(count_q) == CntW'(MAX_BLOCKS), "overflow set while table had room")

endmodule

>>> hdl/cbpm_ctrl.sv
// Controller of the block position mapper: handshakes, query walk sequencing and output valid.
module cbpm_ctrl import cbpm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   accept;

  // The output register is free when empty or being drained in this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.accept     = accept;
  assign cmd_o.walk       = (state_q == ST_WALK);
  assign cmd_o.load_query = (state_q == ST_FINISH) && out_free;

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((accept && status_i.item_result) || cmd_o.load_query) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && status_i.is_query) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (status_i.walk_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`include "assert_macros.svh"

  `ASSERT_PROP(a_accept_idle, clk_i, rst_ni, accept |-> state_q == ST_IDLE, "item accepted during a query")
  `ASSERT_PROP(a_finish_after_walk, clk_i, rst_ni, state_q == ST_FINISH |-> $past(state_q) == ST_WALK || $past(state_q) == ST_FINISH, "finish not entered from walk")
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.load_query && out_valid_q && out_stall_i, "query result overwrites a waiting beat")

endmodule

>>> hdl/cigar_block_position_mapper.sv
// CIGAR block position mapper: a start record and its operations build a table of aligned
// blocks, an operation marked last returns the alignment end, and a query maps a one-based
// reference position to a read position or back (0 when not covered). A query walks the
// block table through its single read port, one entry per cycle, and holds off new items
// until its result is loaded into the output register. A new item is taken only while the
// output register is empty or its waiting beat leaves in the same cycle.
// Blocks beyond MAX_BLOCKS are not stored and set the overflow flag until the next start.
module cigar_block_position_mapper import cbpm_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencing and handshakes.
  cbpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Cursors, block table and position arithmetic.
  cbpm_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
